/* rtl/sle_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg: scancode line editor shared types and constants
// Scancode codes, result kinds, key class decode, keymap tables and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int LEN_W      = 6;
  localparam int STORE_DEPTH = 64;
  localparam int CHAR_W     = 8;

  localparam logic [7:0] CODE_LIMIT       = 8'd57;
  localparam logic [7:0] CODE_ERASE       = 8'h0E;
  localparam logic [7:0] CODE_ENTER       = 8'h1C;
  localparam logic [7:0] CODE_LSHIFT_DOWN = 8'h2A;
  localparam logic [7:0] CODE_RSHIFT_DOWN = 8'h36;
  localparam logic [7:0] CODE_LSHIFT_UP   = 8'hAA;
  localparam logic [7:0] CODE_RSHIFT_UP   = 8'hB6;
  localparam logic [7:0] CODE_CAPS        = 8'h3A;

  localparam logic [1:0] KIND_ECHO      = 2'd0;
  localparam logic [1:0] KIND_ERASE     = 2'd1;
  localparam logic [1:0] KIND_LINE_CHAR = 2'd2;
  localparam logic [1:0] KIND_LINE_END  = 2'd3;

  typedef enum logic [2:0] {
    CLS_SHIFT_DN = 3'd0,
    CLS_SHIFT_UP = 3'd1,
    CLS_CAPS     = 3'd2,
    CLS_IGNORE   = 3'd3,
    CLS_ERASE    = 3'd4,
    CLS_ENTER    = 3'd5,
    CLS_CHAR     = 3'd6
  } cls_t;

  typedef struct packed {
    logic set_shift;
    logic clr_shift;
    logic tog_caps;
    logic append;
    logic erase;
    logic start_drain;
    logic emit_echo;
    logic emit_erase;
    logic emit_char;
    logic emit_end;
  } cmd_t;

  typedef struct packed {
    cls_t cls;
    logic len_zero;
    logic len_full;
    logic idx_last;
    logic out_free;
  } sts_t;

  function automatic cls_t classify(input logic [7:0] code);
    cls_t c;
    if (code == CODE_LSHIFT_DOWN || code == CODE_RSHIFT_DOWN) c = CLS_SHIFT_DN;
    else if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) c = CLS_SHIFT_UP;
    else if (code == CODE_CAPS) c = CLS_CAPS;
    else if (code > CODE_LIMIT) c = CLS_IGNORE;
    else if (code == CODE_ERASE) c = CLS_ERASE;
    else if (code == CODE_ENTER) c = CLS_ENTER;
    else c = CLS_CHAR;
    return c;
  endfunction

  function automatic logic [7:0] keymap_lower(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd2:  ch = 8'h31;
      6'd3:  ch = 8'h32;
      6'd4:  ch = 8'h33;
      6'd5:  ch = 8'h34;
      6'd6:  ch = 8'h35;
      6'd7:  ch = 8'h36;
      6'd8:  ch = 8'h37;
      6'd9:  ch = 8'h38;
      6'd10: ch = 8'h39;
      6'd11: ch = 8'h30;
      6'd12: ch = 8'h2D;
      6'd13: ch = 8'h3D;
      6'd16: ch = 8'h71;
      6'd17: ch = 8'h77;
      6'd18: ch = 8'h65;
      6'd19: ch = 8'h72;
      6'd20: ch = 8'h74;
      6'd21: ch = 8'h79;
      6'd22: ch = 8'h75;
      6'd23: ch = 8'h69;
      6'd24: ch = 8'h6F;
      6'd25: ch = 8'h70;
      6'd26: ch = 8'h5B;
      6'd27: ch = 8'h5D;
      6'd30: ch = 8'h61;
      6'd31: ch = 8'h73;
      6'd32: ch = 8'h64;
      6'd33: ch = 8'h66;
      6'd34: ch = 8'h67;
      6'd35: ch = 8'h68;
      6'd36: ch = 8'h6A;
      6'd37: ch = 8'h6B;
      6'd38: ch = 8'h6C;
      6'd39: ch = 8'h3B;
      6'd40: ch = 8'h27;
      6'd41: ch = 8'h60;
      6'd43: ch = 8'h5C;
      6'd44: ch = 8'h7A;
      6'd45: ch = 8'h78;
      6'd46: ch = 8'h63;
      6'd47: ch = 8'h76;
      6'd48: ch = 8'h62;
      6'd49: ch = 8'h6E;
      6'd50: ch = 8'h6D;
      6'd51: ch = 8'h2C;
      6'd52: ch = 8'h2E;
      6'd53: ch = 8'h2F;
      6'd57: ch = 8'h20;
      default: ch = 8'h3F;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] keymap_upper(input logic [5:0] idx);
    logic [7:0] ch;
    case (idx)
      6'd2:  ch = 8'h21;
      6'd3:  ch = 8'h40;
      6'd4:  ch = 8'h23;
      6'd5:  ch = 8'h24;
      6'd6:  ch = 8'h25;
      6'd7:  ch = 8'h5E;
      6'd8:  ch = 8'h26;
      6'd9:  ch = 8'h2A;
      6'd10: ch = 8'h28;
      6'd11: ch = 8'h29;
      6'd12: ch = 8'h5F;
      6'd13: ch = 8'h2B;
      6'd16: ch = 8'h51;
      6'd17: ch = 8'h57;
      6'd18: ch = 8'h45;
      6'd19: ch = 8'h52;
      6'd20: ch = 8'h54;
      6'd21: ch = 8'h59;
      6'd22: ch = 8'h55;
      6'd23: ch = 8'h49;
      6'd24: ch = 8'h4F;
      6'd25: ch = 8'h50;
      6'd26: ch = 8'h7B;
      6'd27: ch = 8'h7D;
      6'd30: ch = 8'h41;
      6'd31: ch = 8'h53;
      6'd32: ch = 8'h44;
      6'd33: ch = 8'h46;
      6'd34: ch = 8'h47;
      6'd35: ch = 8'h48;
      6'd36: ch = 8'h4A;
      6'd37: ch = 8'h4B;
      6'd38: ch = 8'h4C;
      6'd39: ch = 8'h3A;
      6'd40: ch = 8'h22;
      6'd41: ch = 8'h7E;
      6'd43: ch = 8'h7C;
      6'd44: ch = 8'h5A;
      6'd45: ch = 8'h58;
      6'd46: ch = 8'h43;
      6'd47: ch = 8'h56;
      6'd48: ch = 8'h42;
      6'd49: ch = 8'h4E;
      6'd50: ch = 8'h4D;
      6'd51: ch = 8'h3C;
      6'd52: ch = 8'h3E;
      6'd57: ch = 8'h20;
      default: ch = 8'h3F;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/scancode_line_editor.sv */
`timescale 1ns / 1ps
// A result is registered: it appears in the cycle after the item that causes it is taken;
// on enter with a non-empty line the first line character goes through the line store
// read register and then the result register. Items are taken one per cycle while idle;
// enter on n line characters gives n + 1 results, at most one per cycle from the read port.
// An item is taken only while no result is held back by out_stall.
// Reset clears shift, caps, line length and the drain sequencer, not the line store.
// ----------------------------------------------------------------------------
// scancode_line_editor: set-1 scancode line editor
// Maps scancodes to characters, echoes them, buffers the line and sends it
// out on enter.
// ----------------------------------------------------------------------------
module scancode_line_editor
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = 63
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_char_code,
  output logic       out_last
);

  cmd_t cmd;
  sts_t sts;

  sle_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  sle_datapath #(
    .LINE_CAPACITY (LINE_CAPACITY)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_scancode   (in_scancode),
    .cmd           (cmd),
    .sts           (sts),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .out_kind      (out_kind),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

/* rtl/sle_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module sle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/sle_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_datapath: line editor datapath
// Modifier flags, line length, drain index, line store and result register.
// ----------------------------------------------------------------------------
module sle_datapath
  import sle_pkg::*;
#(
  parameter int LINE_CAPACITY = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_scancode,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_char_code,
  output logic        out_last
);

  logic             shift_r, shift_nxt;
  logic             caps_r, caps_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [LEN_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [7:0]       out_char_r, out_char_nxt;
  logic             out_last_r, out_last_nxt;

  logic [CHAR_W-1:0] key_char;
  logic [CHAR_W-1:0] rd_data;
  logic              rd_en;
  logic [LEN_W-1:0]  rd_addr;
  logic              any_emit;

  assign key_char = (shift_r || caps_r) ? keymap_upper(in_scancode[5:0])
                                        : keymap_lower(in_scancode[5:0]);

  assign rd_en   = cmd.start_drain || cmd.emit_char;
  assign rd_addr = cmd.start_drain ? '0 : idx_r + LEN_W'(1);

  sle_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (cmd.append),
    .waddr (len_r),
    .wdata (key_char),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign any_emit = cmd.emit_echo || cmd.emit_erase || cmd.emit_char || cmd.emit_end;

  always_comb begin
    shift_nxt = shift_r;
    caps_nxt  = caps_r;
    len_nxt   = len_r;
    idx_nxt   = idx_r;
    if (cmd.set_shift) shift_nxt = 1'b1;
    if (cmd.clr_shift) shift_nxt = 1'b0;
    if (cmd.tog_caps)  caps_nxt  = ~caps_r;
    if (cmd.append)    len_nxt   = len_r + LEN_W'(1);
    if (cmd.erase)     len_nxt   = len_r - LEN_W'(1);
    if (cmd.emit_end)  len_nxt   = '0;
    if (cmd.start_drain) idx_nxt = '0;
    if (cmd.emit_char)   idx_nxt = idx_r + LEN_W'(1);
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (any_emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.emit_echo) begin
      out_kind_nxt = KIND_ECHO;
      out_char_nxt = key_char;
      out_last_nxt = 1'b1;
    end else if (cmd.emit_erase) begin
      out_kind_nxt = KIND_ERASE;
      out_char_nxt = '0;
      out_last_nxt = 1'b1;
    end else if (cmd.emit_char) begin
      out_kind_nxt = KIND_LINE_CHAR;
      out_char_nxt = rd_data;
      out_last_nxt = 1'b0;
    end else if (cmd.emit_end) begin
      out_kind_nxt = KIND_LINE_END;
      out_char_nxt = '0;
      out_last_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r     <= 1'b0;
      caps_r      <= 1'b0;
      len_r       <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      shift_r     <= shift_nxt;
      caps_r      <= caps_nxt;
      len_r       <= len_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign sts.cls      = classify(in_scancode);
  assign sts.len_zero = (len_r == '0);
  assign sts.len_full = (len_r >= LEN_W'(LINE_CAPACITY));
  assign sts.idx_last = ((idx_r + LEN_W'(1)) == len_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

endmodule

/* rtl/sle_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_ctrl: line editor controller
// Takes items while idle, issues datapath commands and sequences the line
// drain after enter.
// ----------------------------------------------------------------------------
module sle_ctrl
  import sle_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_DRAIN = 3'b010,
    ST_LEND  = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = !((state_r == ST_IDLE) && sts.out_free);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (sts.cls)
            CLS_SHIFT_DN: cmd.set_shift = 1'b1;
            CLS_SHIFT_UP: cmd.clr_shift = 1'b1;
            CLS_CAPS:     cmd.tog_caps  = 1'b1;
            CLS_ERASE: begin
              if (!sts.len_zero) begin
                cmd.erase      = 1'b1;
                cmd.emit_erase = 1'b1;
              end
            end
            CLS_ENTER: begin
              if (sts.len_zero) begin
                cmd.emit_end = 1'b1;
              end else begin
                cmd.start_drain = 1'b1;
                state_nxt       = ST_DRAIN;
              end
            end
            CLS_CHAR: begin
              cmd.emit_echo = 1'b1;
              cmd.append    = !sts.len_full;
            end
            default: ;
          endcase
        end
      end
      ST_DRAIN: begin
        if (sts.out_free) begin
          cmd.emit_char = 1'b1;
          if (sts.idx_last) begin
            state_nxt = ST_LEND;
          end
        end
      end
      ST_LEND: begin
        if (sts.out_free) begin
          cmd.emit_end = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/sle_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_checker: port-level checks for the scancode line editor
// Watches the item handshakes and result framing of the top level.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] out_kind,
  input logic [7:0] out_char_code,
  input logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind)
      && $stable(out_char_code) && $stable(out_last))
    else $error("stalled result changed");

  a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("item taken while a result is held back");

  a_last_framing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last == (out_kind != KIND_LINE_CHAR)))
    else $error("last flag does not match result kind");

  a_no_char_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_ERASE || out_kind == KIND_LINE_END)
      |-> out_char_code == 8'd0)
    else $error("erase or line end carries a character");

  a_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_LINE_CHAR |-> in_stall)
    else $error("item taken before line end was sent");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (.*);

/* tb/sv/scancode_line_editor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scancode_line_editor_tb: self-checking bench for the scancode line editor
// Drives set-1 scancodes (directed corner cases, then typed lines with
// shift, caps, erase and noise mixed in) under random stalls on both sides.
// A scoreboard tracks shift, caps and the line buffer. It compares every
// echo, erase, line character and line end with the predicted stream.
// ----------------------------------------------------------------------------

import sle_pkg::*;

typedef struct packed {
  logic [1:0] kind;
  logic [7:0] char_code;
  logic       last;
} editor_result_t;

class line_editor_scoreboard;
  int unsigned    capacity;
  bit             shift_held;
  bit             caps_on;
  logic [7:0]     line_chars [64];
  int unsigned    line_len;
  logic [8*58-1:0] lower_keys;
  logic [8*58-1:0] upper_keys;
  editor_result_t predicted_results [$];
  int unsigned    mismatches;
  int unsigned    results_checked;
  int unsigned    scancodes_taken;
  int unsigned    longest_drain;
  int unsigned    appends_refused;

  function new(int unsigned cap);
    capacity        = cap;
    shift_held      = 1'b0;
    caps_on         = 1'b0;
    line_len        = 0;
    mismatches      = 0;
    results_checked = 0;
    scancodes_taken = 0;
    longest_drain   = 0;
    appends_refused = 0;
    lower_keys = "??1234567890-=??qwertyuiop[]??asdfghjkl;'`?\\zxcvbnm,./??? ";
    upper_keys = "??!@#$%^&*()_+??QWERTYUIOP{}??ASDFGHJKL:\"~?|ZXCVBNM<>???? ";
  endfunction

  function void predict(logic [1:0] kind, logic [7:0] ch, logic last);
    editor_result_t r;
    r.kind      = kind;
    r.char_code = ch;
    r.last      = last;
    predicted_results.push_back(r);
  endfunction

  function void note_scancode(logic [7:0] code);
    logic [7:0] ch;
    int unsigned idx;
    scancodes_taken++;
    if (code == CODE_LSHIFT_DOWN || code == CODE_RSHIFT_DOWN) begin
      shift_held = 1'b1;
    end else if (code == CODE_LSHIFT_UP || code == CODE_RSHIFT_UP) begin
      shift_held = 1'b0;
    end else if (code == CODE_CAPS) begin
      caps_on = !caps_on;
    end else if (code > CODE_LIMIT) begin
      // ignored key
    end else if (code == CODE_ERASE) begin
      if (line_len > 0) begin
        line_len--;
        predict(KIND_ERASE, 8'h00, 1'b1);
      end
    end else if (code == CODE_ENTER) begin
      for (int i = 0; i < line_len; i++) begin
        predict(KIND_LINE_CHAR, line_chars[i], 1'b0);
      end
      predict(KIND_LINE_END, 8'h00, 1'b1);
      if (line_len + 1 > longest_drain) begin
        longest_drain = line_len + 1;
      end
      line_len = 0;
    end else begin
      idx = 57 - code;
      ch = (shift_held || caps_on) ? upper_keys[idx*8 +: 8] : lower_keys[idx*8 +: 8];
      predict(KIND_ECHO, ch, 1'b1);
      if (line_len < capacity) begin
        line_chars[line_len] = ch;
        line_len++;
      end else begin
        appends_refused++;
      end
    end
  endfunction

  function void report(string what, editor_result_t got, editor_result_t want);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: kind %0d char %02h last %0d, expected kind %0d char %02h last %0d",
               what, got.kind, got.char_code, got.last,
               want.kind, want.char_code, want.last);
    end
  endfunction

  function void check_result(logic [1:0] kind, logic [7:0] ch, logic last);
    editor_result_t got;
    editor_result_t want;
    got.kind      = kind;
    got.char_code = ch;
    got.last      = last;
    results_checked++;
    if (predicted_results.size() == 0) begin
      want = '0;
      report("unexpected result", got, want);
    end else begin
      want = predicted_results.pop_front();
      if (got.kind !== want.kind || got.char_code !== want.char_code ||
          got.last !== want.last) begin
        report("result mismatch", got, want);
      end
    end
  endfunction

  function int unsigned pending();
    return predicted_results.size();
  endfunction
endclass

module scancode_line_editor_tb;

  localparam int LINE_CAP    = 63;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;

  logic       clk         = 1'b0;
  logic       rst_n       = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic [7:0] in_scancode = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_char_code;
  logic       out_last;

  line_editor_scoreboard sb;
  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned keys_counted   = 0;
  int unsigned cycle_count    = 0;
  bit          hold_req       = 1'b0;

  scancode_line_editor #(
    .LINE_CAPACITY(LINE_CAP)
  ) uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_scancode  (in_scancode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_kind     (out_kind),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // results first: results are registered, so a result never belongs to this edge's item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        sb.check_result(out_kind, out_char_code, out_last);
      end
      if (in_valid && !in_stall) begin
        sb.note_scancode(in_scancode);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic send_scancode(input logic [7:0] code);
    in_valid    <= 1'b1;
    in_scancode <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (!(code > CODE_LIMIT && code != CODE_CAPS && code != CODE_LSHIFT_UP &&
          code != CODE_RSHIFT_UP)) begin
      keys_counted++;
    end
    if ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic type_line(input int n_keys, input bit plain);
    int unsigned r;
    logic [7:0] c;
    for (int i = 0; i < n_keys; i++) begin
      r = plain ? 99 : $urandom_range(99);
      if (r < 8) begin
        c = $urandom_range(1) ? CODE_LSHIFT_DOWN : CODE_RSHIFT_DOWN;
      end else if (r < 14) begin
        c = $urandom_range(1) ? CODE_LSHIFT_UP : CODE_RSHIFT_UP;
      end else if (r < 17) begin
        c = CODE_CAPS;
      end else if (r < 25) begin
        c = CODE_ERASE;
      end else if (r < 30) begin
        c = 8'($urandom_range(255));
      end else begin
        do c = 8'($urandom_range(CODE_LIMIT)); while (c == CODE_ERASE || c == CODE_ENTER);
      end
      send_scancode(c);
    end
    // an unfinished line now and then
    if (plain || $urandom_range(9) != 0) begin
      send_scancode(CODE_ENTER);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    logic [7:0] directed_codes [0:23];
    directed_codes = '{CODE_ERASE, CODE_ENTER, 8'h00, 8'h39, 8'h3B, 8'hFF, 8'h80,
                       CODE_CAPS, 8'h10, 8'h35, CODE_LSHIFT_DOWN, 8'h02, CODE_LSHIFT_UP,
                       CODE_RSHIFT_DOWN, 8'h0D, CODE_CAPS, 8'h28, CODE_RSHIFT_UP, 8'h28,
                       CODE_CAPS, 8'h1E, CODE_ERASE, 8'h2B, CODE_ENTER};
    sb = new(LINE_CAP);
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_gap_pct   = 14;
    recv_stall_pct = 66;
    foreach (directed_codes[i]) begin
      send_scancode(directed_codes[i]);
    end
    type_line(75, 1'b1);
    while (keys_counted < 70) type_line($urandom_range(1, 12), 1'b0);
    // long receiver hold-off while items keep coming
    hold_req = 1'b1;
    type_line(12, 1'b1);
    wait_drained();

    send_gap_pct   = 66;
    recv_stall_pct = 14;
    while (keys_counted < 140) type_line($urandom_range(1, 12), 1'b0);

    send_gap_pct   = 0;
    recv_stall_pct = 0;
    type_line(68, 1'b1);
    while (keys_counted < 210) type_line($urandom_range(1, 12), 1'b0);

    wait_drained();
    repeat (20) @(posedge clk);

    $display("covered %0d scancodes and %0d checked results, %0d mismatches",
             sb.scancodes_taken, sb.results_checked, sb.mismatches);
    $display("longest line drain %0d results, %0d appends refused on a full line",
             sb.longest_drain, sb.appends_refused);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
